FILE: src/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  // Frame geometry
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PFN_W       = ADDR_W - FRAME_SHIFT;

  // Flag store rows hold 32 frame flags each
  localparam int unsigned ROW_BITS    = 32;
  localparam int unsigned ROW_SEL_W   = 5;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NONE_FREE   = 3'd1;
  localparam logic [2:0] ST_BELOW_BASE  = 3'd2;
  localparam logic [2:0] ST_BEYOND      = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration registers
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic        REG_BASE    = 1'b0;
  localparam logic        REG_MEMSIZE = 1'b1;
  localparam logic [31:0] BASE_RESET    = 32'h0020_0000;
  localparam logic [31:0] MEMSIZE_RESET = 32'h0060_0000;

  // Controller to datapath
  typedef struct packed {
    logic       clr_step;
    logic       req_take;
    logic       prep;
    logic       scan_start;
    logic       scan_run;
    logic       alloc_wr;
    logic       free_wr;
    logic       rsp_load;
    logic [2:0] status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic kind;
    logic no_frames;
    logic below;
    logic beyond;
    logic found;
    logic miss;
    logic flag_set;
    logic rsp_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/pfa_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pfa_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] free_addr;

  modport source (output valid, output kind, output free_addr, input ready);
  modport sink   (input valid, input kind, input free_addr, output ready);
endinterface

interface pfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] frame_addr;

  modport source (output valid, output status, output frame_addr, input ready);
  modport sink   (input valid, input status, input frame_addr, output ready);
endinterface

`default_nettype wire

FILE: src/pfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_fire_i,
  input  wire pfa_pkg::sts_t sts_i,
  output logic               req_ready_o,
  output pfa_pkg::cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_PREP   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_FCHECK = 8'b0010_0000,
    S_RESP   = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] st_q, st_d;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.req_take = req_fire_i;
        if (req_fire_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.kind == pfa_pkg::KIND_ALLOC) begin
          if (sts_i.no_frames) begin
            st_d    = pfa_pkg::ST_NONE_FREE;
            state_d = S_RESP;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else begin
          priority if (sts_i.below) begin
            st_d    = pfa_pkg::ST_BELOW_BASE;
            state_d = S_RESP;
          end else if (sts_i.beyond) begin
            st_d    = pfa_pkg::ST_BEYOND;
            state_d = S_RESP;
          end else begin
            state_d = S_FCHECK;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        priority if (sts_i.found) begin
          cmd_o.alloc_wr = 1'b1;
          st_d           = pfa_pkg::ST_OK;
          state_d        = S_RESP;
        end else if (sts_i.miss) begin
          st_d    = pfa_pkg::ST_NONE_FREE;
          state_d = S_RESP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_FCHECK: begin
        if (sts_i.flag_set) begin
          cmd_o.free_wr = 1'b1;
          st_d          = pfa_pkg::ST_OK;
        end else begin
          st_d = pfa_pkg::ST_DOUBLE_FREE;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        cmd_o.status = st_q;
        if (!sts_i.rsp_busy) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= pfa_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/pfa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pfa_dp #(
  parameter int unsigned MAX_PAGES = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   base_i,
  input  wire logic [31:0]   memsize_i,
  input  wire logic          req_kind_i,
  input  wire logic [31:0]   req_addr_i,
  input  wire pfa_pkg::cmd_t cmd_i,
  output pfa_pkg::sts_t      sts_o,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output logic [2:0]         rsp_status_o,
  output logic [31:0]        rsp_addr_o
);

  localparam int unsigned ROWS   = (MAX_PAGES + pfa_pkg::ROW_BITS - 1) / pfa_pkg::ROW_BITS;
  localparam int unsigned WA_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PTR_W  = WA_W + pfa_pkg::ROW_SEL_W;
  localparam int unsigned CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int unsigned LEFT_W = WA_W + 1;
  localparam int unsigned NM_W   = CNT_W + pfa_pkg::ROW_SEL_W;

  // Flag store, one row of 32 frame flags per word
  logic [pfa_pkg::ROW_BITS-1:0] mem_q [ROWS];
  logic [pfa_pkg::ROW_BITS-1:0] rdata_q;

  // Request and derived checks
  logic                     kind_q;
  logic [31:0]              addr_q;
  logic [CNT_W-1:0]         n_q;
  logic                     below_q, beyond_q;
  logic [pfa_pkg::PFN_W-1:0] fidx_q;

  // Scan issue and evaluate stages
  logic [PTR_W-1:0]  ptr_q;
  logic [4:0]        wbit0_q;
  logic [WA_W-1:0]   iss_addr_q;
  logic [LEFT_W-1:0] iss_left_q;
  logic              iss_first_q;
  logic              e_valid_q, e_first_q, e_last_q;
  logic [WA_W-1:0]   e_addr_q;

  logic [WA_W-1:0]   clr_addr_q;
  logic [31:0]       res_addr_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_addr_q;

  // Combinational helpers
  logic [31:0]               diff;
  logic [pfa_pkg::PFN_W-1:0] pages;
  logic [CNT_W-1:0]          n_calc;
  logic [NM_W-1:0]           nm1;
  logic [WA_W-1:0]           lw;
  logic [4:0]                lastbit;
  logic [PTR_W-1:0]          idx0;
  logic [31:0]               lo_mask, hi_mask, mask, freev;
  logic [4:0]                pos;
  logic [PTR_W-1:0]          idx_found;
  logic [WA_W-1:0]           fword;
  logic [4:0]                fbit;
  logic                      issue;
  logic [WA_W-1:0]           rd_addr;
  logic                      we;
  logic [WA_W-1:0]           waddr;
  logic [31:0]               wdata;

  function automatic logic [4:0] first_set(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (v[j]) begin
        p = 5'(j);
      end
    end
    return p;
  endfunction

  // Managed frame count, clamped to the store size
  assign diff  = memsize_i - base_i;
  assign pages = diff[31:pfa_pkg::FRAME_SHIFT];
  always_comb begin
    if (memsize_i <= base_i) begin
      n_calc = '0;
    end else if (pages > pfa_pkg::PFN_W'(MAX_PAGES)) begin
      n_calc = CNT_W'(MAX_PAGES);
    end else begin
      n_calc = pages[CNT_W-1:0];
    end
  end

  assign nm1     = NM_W'(n_q) - NM_W'(1);
  assign lw      = nm1[WA_W+4:5];
  assign lastbit = nm1[4:0];
  assign idx0    = (32'(ptr_q) < 32'(n_q)) ? ptr_q : '0;

  // Evaluate one row: flags outside the window or the current sweep segment are masked
  assign lo_mask = 32'hFFFF_FFFF << wbit0_q;
  assign hi_mask = (e_addr_q == lw) ? (32'hFFFF_FFFF >> (5'd31 - lastbit)) : 32'hFFFF_FFFF;
  always_comb begin
    mask = hi_mask;
    if (e_first_q) begin
      mask = mask & lo_mask;
    end
    if (e_last_q) begin
      mask = mask & ~lo_mask;
    end
  end
  assign freev     = ~rdata_q & mask;
  assign pos       = first_set(freev);
  assign idx_found = {e_addr_q, pos};

  assign fword = fidx_q[WA_W+4:5];
  assign fbit  = fidx_q[4:0];
  assign issue = cmd_i.scan_run && (iss_left_q != '0);

  assign rd_addr = cmd_i.scan_run ? iss_addr_q : fword;

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_q;
    wdata = '0;
    priority if (cmd_i.clr_step) begin
      we = 1'b1;
    end else if (cmd_i.alloc_wr) begin
      we    = 1'b1;
      waddr = e_addr_q;
      wdata = rdata_q | (32'd1 << pos);
    end else if (cmd_i.free_wr) begin
      we    = 1'b1;
      waddr = fword;
      wdata = rdata_q & ~(32'd1 << fbit);
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_take) begin
      kind_q <= req_kind_i;
      addr_q <= req_addr_i;
    end
    if (cmd_i.prep) begin
      n_q        <= n_calc;
      below_q    <= addr_q < base_i;
      beyond_q   <= addr_q >= memsize_i;
      fidx_q     <= pfa_pkg::PFN_W'((addr_q - base_i) >> pfa_pkg::FRAME_SHIFT);
      res_addr_q <= '0;
    end else if (cmd_i.alloc_wr) begin
      res_addr_q <= base_i + (32'(idx_found) << pfa_pkg::FRAME_SHIFT);
    end
    if (cmd_i.scan_start) begin
      wbit0_q <= idx0[4:0];
    end
    if (issue) begin
      e_first_q <= iss_first_q;
      e_last_q  <= (iss_left_q == LEFT_W'(1));
      e_addr_q  <= iss_addr_q;
    end
    if (cmd_i.rsp_load) begin
      out_status_q <= cmd_i.status;
      out_addr_q   <= res_addr_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      iss_addr_q  <= '0;
      iss_left_q  <= '0;
      iss_first_q <= 1'b0;
      e_valid_q   <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + WA_W'(1);
      end
      if (cmd_i.scan_start) begin
        iss_addr_q  <= idx0[PTR_W-1:5];
        iss_left_q  <= LEFT_W'(lw) + LEFT_W'(2);
        iss_first_q <= 1'b1;
        e_valid_q   <= 1'b0;
      end else begin
        e_valid_q <= issue;
        if (issue) begin
          iss_addr_q  <= (iss_addr_q == lw) ? '0 : iss_addr_q + WA_W'(1);
          iss_left_q  <= iss_left_q - LEFT_W'(1);
          iss_first_q <= 1'b0;
        end
      end
      if (cmd_i.alloc_wr) begin
        ptr_q <= idx_found;
      end
      if (cmd_i.rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = (clr_addr_q == WA_W'(ROWS - 1));
    sts_o.kind      = kind_q;
    sts_o.no_frames = (n_q == '0);
    sts_o.below     = below_q;
    sts_o.beyond    = beyond_q || (fidx_q >= pfa_pkg::PFN_W'(n_q));
    sts_o.found     = e_valid_q && (freev != '0);
    sts_o.miss      = e_valid_q && e_last_q && (freev == '0);
    sts_o.flag_set  = rdata_q[fbit];
    sts_o.rsp_busy  = out_valid_q && !rsp_ready_i;
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_addr_o   = out_addr_q;

endmodule

`default_nettype wire

FILE: src/page_frame_allocator.sv
// Free request: range errors are answered straight from the decide state; an in-range
// release reads its flag row and answers ok or double free. Allocate: a next-fit scan
// reads one 32-frame flag row per cycle, over the whole window, until a free frame turns up.
// One request in flight; the next is taken once the result sits in the output register.
// Reset: async active low; a clearing pass zeroes the flag store, one row at a time,
// before the first request is taken. Registers reset to base 2 MiB, size 6 MiB.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_allocator #(
  parameter int unsigned MAX_PAGES = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  pfa_req_if.sink                               req_i,
  pfa_rsp_if.source                             rsp_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pfa_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  // Configuration registers: base at byte 0, memory size at byte 4
  logic [31:0] base_q, memsize_q;
  logic        cfg_wr;
  logic        cfg_sel;

  // Control and status between sequencer and datapath
  pfa_pkg::cmd_t cmd;
  pfa_pkg::sts_t sts;
  logic          req_ready;
  logic          req_fire;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (cfg_sel == pfa_pkg::REG_MEMSIZE) ? memsize_q : base_q;

  // Writes must arrive only while idle, a user rule left unchecked; they apply directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= pfa_pkg::BASE_RESET;
      memsize_q <= pfa_pkg::MEMSIZE_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == pfa_pkg::REG_BASE) begin
        base_q <= pwdata;
      end else begin
        memsize_q <= pwdata;
      end
    end
  end

  // Ready only in the idle state; the clearing pass keeps it low
  assign req_i.ready = req_ready;
  assign req_fire    = req_i.valid && req_ready;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_fire_i  (req_fire),
    .sts_i       (sts),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  // Flag store, scan pipeline, free checks and the output register
  pfa_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_i       (base_q),
    .memsize_i    (memsize_q),
    .req_kind_i   (req_i.kind),
    .req_addr_i   (req_i.free_addr),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_addr_o   (rsp_o.frame_addr)
  );

  // One request at a time: ready drops after every accepted beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // Only a successful allocation carries an address
  a_err_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != pfa_pkg::ST_OK) |-> (rsp_o.frame_addr == 32'd0))
    else $error("error result carries a frame address");

  // Status stays within the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.status <= pfa_pkg::ST_DOUBLE_FREE))
    else $error("undefined status code");

  // A loaded result is presented on the next cycle
  a_rsp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rsp_load |=> rsp_o.valid)
    else $error("result load lost");

endmodule

`default_nettype wire

FILE: bench/pfa_frame_checker.sv
`timescale 1ns / 1ps

module pfa_frame_checker #(
  parameter int unsigned NUM_FRAMES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pfa_req_if                             req_i,
  pfa_rsp_if                             rsp_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [pfa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int unsigned                    mismatches_o,
  output int unsigned                    owed_count_o,
  output int unsigned                    status_hits_o [5]
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] frame_addr;
  } frame_result_t;

  logic [31:0]   base_reg;
  logic [31:0]   memsize_reg;
  logic          frame_taken [NUM_FRAMES];
  int unsigned   scan_cursor;
  frame_result_t owed_results [$];
  int unsigned   fails;

  function automatic int unsigned managed_frames();
    logic [31:0] span;
    if (memsize_reg <= base_reg) return 0;
    span = (memsize_reg - base_reg) >> pfa_pkg::FRAME_SHIFT;
    return (span > NUM_FRAMES) ? NUM_FRAMES : span;
  endfunction

  // Next-fit allocation or range-checked release; updates the flag copy.
  function automatic frame_result_t serve_request(input logic kind, input logic [31:0] addr);
    frame_result_t res;
    int unsigned   total;
    int unsigned   idx;
    logic [31:0]   slot;
    res = '{status: pfa_pkg::ST_NONE_FREE, frame_addr: '0};
    total = managed_frames();
    if (kind == pfa_pkg::KIND_ALLOC) begin
      // a cursor left outside a shrunken window restarts at frame 0
      idx = (scan_cursor < total) ? scan_cursor : 0;
      for (int unsigned k = 0; k < total; k++) begin
        if (!frame_taken[idx]) begin
          frame_taken[idx] = 1'b1;
          scan_cursor = idx;
          res.status = pfa_pkg::ST_OK;
          res.frame_addr = base_reg + (idx << pfa_pkg::FRAME_SHIFT);
          return res;
        end
        idx = (idx + 1 == total) ? 0 : idx + 1;
      end
      return res;
    end
    if (addr < base_reg) begin
      res.status = pfa_pkg::ST_BELOW_BASE;
    end else if (addr >= memsize_reg) begin
      res.status = pfa_pkg::ST_BEYOND;
    end else begin
      slot = (addr - base_reg) >> pfa_pkg::FRAME_SHIFT;
      if (slot >= total) begin
        res.status = pfa_pkg::ST_BEYOND;
      end else if (!frame_taken[slot]) begin
        res.status = pfa_pkg::ST_DOUBLE_FREE;
      end else begin
        frame_taken[slot] = 1'b0;
        res.status = pfa_pkg::ST_OK;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      base_reg    = pfa_pkg::BASE_RESET;
      memsize_reg = pfa_pkg::MEMSIZE_RESET;
      foreach (frame_taken[i]) frame_taken[i] = 1'b0;
      scan_cursor = 0;
      owed_results.delete();
      fails = 0;
      foreach (status_hits_o[i]) status_hits_o[i] <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[pfa_pkg::APB_ADDR_W-1:2] == pfa_pkg::REG_BASE) begin
          base_reg = pwdata;
        end else if (paddr[pfa_pkg::APB_ADDR_W-1:2] == pfa_pkg::REG_MEMSIZE) begin
          memsize_reg = pwdata;
        end
      end
      if (req_i.valid && req_i.ready) begin
        owed_results.push_back(serve_request(req_i.kind, req_i.free_addr));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_results.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: result beat with nothing owed: status %0d addr %h",
                     $time, rsp_i.status, rsp_i.frame_addr);
          end
          fails++;
        end else begin
          want = owed_results.pop_front();
          status_hits_o[want.status] <= status_hits_o[want.status] + 1;
          if (rsp_i.status !== want.status || rsp_i.frame_addr !== want.frame_addr) begin
            if (fails < 10) begin
              $display("%0t: mismatch: expected status %0d addr %h, got status %0d addr %h",
                       $time, want.status, want.frame_addr, rsp_i.status, rsp_i.frame_addr);
            end
            fails++;
          end
        end
      end
    end
    mismatches_o <= fails;
    owed_count_o <= owed_results.size();
  end

endmodule

FILE: bench/tb_page_frame_allocator.sv
`timescale 1ns / 1ps

module tb_page_frame_allocator;

  localparam int unsigned NUM_FRAMES    = 1024;
  localparam int unsigned FRAME_BYTES   = 1 << pfa_pkg::FRAME_SHIFT;
  // Chance in a hundred that a side idles on a given cycle
  localparam int unsigned IDLE_PCT      = 9;
  // Sender runs without gaps while the request count is in this range
  localparam int unsigned CALM_FIRST    = 700;
  localparam int unsigned CALM_LAST     = 1100;
  // Long output stall: starts after this many requests, lasts this many cycles
  localparam int unsigned STALL_AFTER   = 40;
  localparam int unsigned STALL_CYCLES  = 250;
  // Output side stays ready for this long right after the stall
  localparam int unsigned STEADY_CYCLES = 1500;
  // Settle time after the final drain, longer than the slowest allocation
  localparam int unsigned END_SETTLE    = 60;

  logic clk_i;
  logic rst_ni;

  pfa_req_if req_ch ();
  pfa_rsp_if rsp_ch ();

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [pfa_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  int unsigned mismatches;
  int unsigned owed_count;
  int unsigned status_hits [5];

  // Stimulus view of the current window, used only to aim free requests
  logic [31:0] cur_base;
  logic [31:0] cur_size;
  int unsigned win_frames;
  logic [31:0] held_frames [$];
  int unsigned req_beats;
  int unsigned settings_run;

  page_frame_allocator #(
    .MAX_PAGES (NUM_FRAMES)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pfa_frame_checker #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches_o  (mismatches),
    .owed_count_o  (owed_count),
    .status_hits_o (status_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Remember frames that were handed out so that most releases hit a used frame.
  // A release also answers ok, but with a zero address, so it never lands here.
  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == pfa_pkg::ST_OK &&
        rsp_ch.frame_addr != '0) begin
      held_frames.push_back(rsp_ch.frame_addr);
    end
  end

  // Result side: random back-pressure, one long hold once the block has work queued
  // behind it, then a stretch that is always ready, then random again.
  initial begin
    rsp_ch.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    while (req_beats < STALL_AFTER) begin
      rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk_i);
    end
    // hold off while the sender keeps offering, so the input side backs up
    rsp_ch.ready <= 1'b0;
    repeat (STALL_CYCLES) @(posedge clk_i);
    rsp_ch.ready <= 1'b1;
    repeat (STEADY_CYCLES) @(posedge clk_i);
    forever begin
      rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk_i);
    end
  end

  // Offer one request beat and hold it until the block takes it. Call at a clock edge.
  // Valid is only lowered when a gap is actually taken, so it never drops and rises
  // within one step.
  task automatic send_req(input logic kind, input logic [31:0] addr);
    bit quiet;
    quiet = (req_beats >= CALM_FIRST) && (req_beats < CALM_LAST);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.free_addr <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
    req_beats++;
  endtask

  // Setup cycle, then access cycle until pready. The bus is released by the caller,
  // so back-to-back writes never lower and raise psel in the same step.
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Mostly allocations and well-aimed releases, plus window-edge, below-base,
  // above-memory and fully random addresses.
  task automatic random_mix(input int unsigned items);
    int unsigned pick;
    int unsigned slot;
    logic [31:0] addr;
    for (int unsigned i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      addr = $urandom;
      if (pick < 50) begin
        send_req(pfa_pkg::KIND_ALLOC, addr);
      end else begin
        if (pick < 72 && held_frames.size() != 0) begin
          // release a frame we were given, at a random offset inside it
          slot = $urandom_range(held_frames.size() - 1);
          addr = held_frames[slot] + $urandom_range(FRAME_BYTES - 1);
          held_frames.delete(slot);
        end else if (pick < 86) begin
          // anywhere in the window, reaching up to three frames past its end
          addr = cur_base + $urandom_range(win_frames + 2) * FRAME_BYTES
                 + $urandom_range(FRAME_BYTES - 1);
        end else if (pick < 92 && cur_base != '0) begin
          addr = $urandom_range(cur_base - 1);
        end else if (pick < 96) begin
          addr = cur_size + $urandom_range(32'hFFFF_FFFF - cur_size);
        end
        send_req(pfa_pkg::KIND_FREE, addr);
      end
    end
  endtask

  // Drain, reprogram both registers while the block is idle, then run random traffic.
  task automatic run_phase(input logic [31:0] base, input logic [31:0] size,
                           input int unsigned items);
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (owed_count != 0);
    write_reg(pfa_pkg::REG_BASE, base);
    write_reg(pfa_pkg::REG_MEMSIZE, size);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_base   = base;
    cur_size   = size;
    win_frames = (size > base) ? ((size - base) >> pfa_pkg::FRAME_SHIFT) : 0;
    if (win_frames > NUM_FRAMES) win_frames = NUM_FRAMES;
    // frames held under the old window mean nothing under the new one
    held_frames.delete();
    settings_run++;
    random_mix(items);
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = pfa_pkg::KIND_ALLOC;
    req_ch.free_addr = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cur_base         = pfa_pkg::BASE_RESET;
    cur_size         = pfa_pkg::MEMSIZE_RESET;
    win_frames       = NUM_FRAMES;
    req_beats        = 0;
    settings_run     = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass on the reset window (1024 frames from 2 MiB). The block's own
    // clearing pass after reset just shows up as a late first ready.
    send_req(pfa_pkg::KIND_ALLOC, 32'h0000_0000);
    send_req(pfa_pkg::KIND_ALLOC, 32'hFFFF_FFFF);
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::BASE_RESET);
    // same frame again, then again through an offset inside it: double free
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::BASE_RESET);
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::BASE_RESET + 32'h0000_0FFF);
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::BASE_RESET + 32'h0000_1FFF);
    // below base: the lowest address and the byte just under the window
    send_req(pfa_pkg::KIND_FREE, 32'h0000_0000);
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::BASE_RESET - 1);
    // at the end of memory and the top of the address space
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::MEMSIZE_RESET);
    send_req(pfa_pkg::KIND_FREE, 32'hFFFF_FFFF);
    // last managed frame, never handed out
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::MEMSIZE_RESET - 1);
    // next-fit resumes at the cursor and reuses the freed frame there
    send_req(pfa_pkg::KIND_ALLOC, 32'h5A5A_A5A5);
    send_req(pfa_pkg::KIND_ALLOC, 32'hA5A5_5A5A);
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::BASE_RESET + 32'h0000_2000);
    send_req(pfa_pkg::KIND_FREE, pfa_pkg::BASE_RESET + 32'h0000_1000);

    random_mix(300);

    // Eight frames: fills up quickly, so exhaustion is hit often, and the cursor
    // left far out by the previous window must restart at frame zero.
    run_phase(32'h1000_0000, 32'h1000_8000, 300);
    // Lowest base, highest size: the count is capped at the frame store depth.
    run_phase(32'h0000_0000, 32'hFFFF_F000, 300);
    // Highest base, zero size: nothing is managed at all.
    run_phase(32'hFFFF_F000, 32'h0000_0000, 150);
    // Unaligned base and size, five whole frames in the window.
    run_phase(32'h0000_3A00, 32'h0000_3A00 + 5 * FRAME_BYTES + 32'h800, 300);
    // Fifteen frames right under the top of the address space.
    run_phase(32'hFFFF_0000, 32'hFFFF_F000, 250);
    // Size equal to base: empty window again.
    run_phase(32'h0020_0000, 32'h0020_0000, 100);
    // Sixteen frames at the reset base.
    run_phase(32'h0020_0000, 32'h0021_0000, 200);

    // Drain, then leave room for anything the block might still emit
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (owed_count != 0);
    repeat (END_SETTLE) @(posedge clk_i);

    $display("Ran %0d requests across %0d register settings, with a %0d-cycle result stall.",
             req_beats, settings_run, STALL_CYCLES);
    $display("Outcomes: %0d ok, %0d none free, %0d below base, %0d beyond memory, %s",
             status_hits[pfa_pkg::ST_OK], status_hits[pfa_pkg::ST_NONE_FREE],
             status_hits[pfa_pkg::ST_BELOW_BASE], status_hits[pfa_pkg::ST_BEYOND],
             $sformatf("%0d double free.", status_hits[pfa_pkg::ST_DOUBLE_FREE]));
    if (mismatches == 0 && owed_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
